### hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge except while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/pfrc_pkg.sv
package pfrc_pkg;

   localparam int RULE_SLOTS  = 64;
   localparam int KEY_WIDTH   = 32;

   localparam int SLOT_W      = 6;
   localparam int PROTO_W     = 8;
   localparam int ADDR_W      = 32;
   localparam int LEN_W       = 6;
   localparam int PORT_W      = 16;
   localparam int PRIO_W      = 16;
   localparam int KEY_FIELD_W = 32;

   localparam int CELL_IDX_W  = ($clog2(RULE_SLOTS) > SLOT_W) ? $clog2(RULE_SLOTS) : SLOT_W;

   localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [LEN_W-1:0]  FULL_LEN = LEN_W'(ADDR_W);

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_WRITE  = 1'b1
   } func_type;

   // Item travelling down the cell chain, with the running best match.
   typedef struct packed {
      func_type                func;
      logic [SLOT_W-1:0]       slot;
      logic                    rule_enable;
      logic [PROTO_W-1:0]      proto_code;
      logic [ADDR_W-1:0]       source_addr;
      logic [LEN_W-1:0]        source_len;
      logic [ADDR_W-1:0]       dest_addr;
      logic [LEN_W-1:0]        dest_len;
      logic [PORT_W-1:0]       source_port_num;
      logic [PORT_W-1:0]       dest_port_num;
      logic [PRIO_W-1:0]       rule_prio;
      logic [KEY_FIELD_W-1:0]  key_value;
      logic                    found;
      logic [PRIO_W-1:0]       best_prio;
      logic [KEY_WIDTH-1:0]    best_key;
   } token_type;

   // Lengths above 32 saturate to an exact match.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      if (len == '0) begin
         m = '0;
      end else if (len >= FULL_LEN) begin
         m = ALL_ONES;
      end else begin
         m = ~(ALL_ONES >> len);
      end
      return m;
   endfunction

endpackage

### hw/rtl/pfrc_if.sv
interface pfrc_req_if import pfrc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [SLOT_W-1:0]      slot;
   logic                   rule_enable;
   logic [PROTO_W-1:0]     proto_code;
   logic [ADDR_W-1:0]      source_addr;
   logic [LEN_W-1:0]       source_len;
   logic [ADDR_W-1:0]      dest_addr;
   logic [LEN_W-1:0]       dest_len;
   logic [PORT_W-1:0]      source_port_num;
   logic [PORT_W-1:0]      dest_port_num;
   logic [PRIO_W-1:0]      rule_prio;
   logic [KEY_FIELD_W-1:0] key_value;

   modport source (
      output valid, func, slot, rule_enable, proto_code, source_addr, source_len,
             dest_addr, dest_len, source_port_num, dest_port_num, rule_prio, key_value,
      input  ready
   );
   modport sink (
      input  valid, func, slot, rule_enable, proto_code, source_addr, source_len,
             dest_addr, dest_len, source_port_num, dest_port_num, rule_prio, key_value,
      output ready
   );
endinterface

interface pfrc_rsp_if import pfrc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [KEY_FIELD_W-1:0] result_key;

   modport source (output valid, hit, result_key, input ready);
   modport sink (input valid, hit, result_key, output ready);
endinterface

### hw/rtl/pfrc_rule_cell.sv
module pfrc_rule_cell import pfrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [CELL_IDX_W-1:0] cell_index,
   input  logic                  up_valid,
   input  token_type             up_tok,
   output logic                  down_valid,
   output token_type             down_tok
);

   logic               active_ff;
   logic [PROTO_W-1:0] proto_ff;
   logic [ADDR_W-1:0]  src_pfx_ff;
   logic [ADDR_W-1:0]  src_mask_ff;
   logic [ADDR_W-1:0]  dst_pfx_ff;
   logic [ADDR_W-1:0]  dst_mask_ff;
   logic [PORT_W-1:0]  sport_ff;
   logic [PORT_W-1:0]  dport_ff;
   logic [PRIO_W-1:0]  prio_ff;
   logic [KEY_WIDTH-1:0] key_ff;

   logic      tok_valid_ff;
   token_type tok_ff;
   token_type tok_in;

   logic rule_match;
   logic write_here;
   logic [ADDR_W-1:0] src_mask_in;
   logic [ADDR_W-1:0] dst_mask_in;

   assign write_here = up_valid && (up_tok.func == FUNC_WRITE) &&
                       (CELL_IDX_W'(up_tok.slot) == cell_index);
   assign src_mask_in = prefix_mask(up_tok.source_len);
   assign dst_mask_in = prefix_mask(up_tok.dest_len);

   assign rule_match = active_ff &&
                       ((proto_ff == '0) || (proto_ff == up_tok.proto_code)) &&
                       ((up_tok.source_addr & src_mask_ff) == src_pfx_ff) &&
                       ((up_tok.dest_addr & dst_mask_ff) == dst_pfx_ff) &&
                       ((sport_ff == '0) || (sport_ff == up_tok.source_port_num)) &&
                       ((dport_ff == '0) || (dport_ff == up_tok.dest_port_num));

   // Strictly greater: an earlier slot keeps a tie.
   always_comb begin
      tok_in = up_tok;
      if ((up_tok.func == FUNC_LOOKUP) && rule_match &&
          (!up_tok.found || (prio_ff > up_tok.best_prio))) begin
         tok_in.found     = 1'b1;
         tok_in.best_prio = prio_ff;
         tok_in.best_key  = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
      end else if (advance) begin
         tok_valid_ff <= up_valid;
         if (write_here) begin
            active_ff <= up_tok.rule_enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff <= tok_in;
         if (write_here && up_tok.rule_enable) begin
            proto_ff    <= up_tok.proto_code;
            src_mask_ff <= src_mask_in;
            src_pfx_ff  <= up_tok.source_addr & src_mask_in;
            dst_mask_ff <= dst_mask_in;
            dst_pfx_ff  <= up_tok.dest_addr & dst_mask_in;
            sport_ff    <= up_tok.source_port_num;
            dport_ff    <= up_tok.dest_port_num;
            prio_ff     <= up_tok.rule_prio;
            key_ff      <= KEY_WIDTH'(up_tok.key_value);
         end
      end
   end

   assign down_valid = tok_valid_ff;
   assign down_tok   = tok_ff;

endmodule

### hw/rtl/pfrc_rsp_stage.sv
module pfrc_rsp_stage import pfrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       last_valid,
   input  token_type  last_tok,
   output logic       advance,
   pfrc_rsp_if.source rsp_chan
);

   logic                   rsp_valid_ff;
   logic                   hit_ff;
   logic [KEY_FIELD_W-1:0] key_ff;
   logic                   hit_in;
   logic [KEY_FIELD_W-1:0] key_in;
   logic                   take;

   // Writes drain at the chain end without a result, so only a lookup can stall.
   assign take    = last_valid && (last_tok.func == FUNC_LOOKUP);
   assign advance = !(take && rsp_valid_ff && !rsp_chan.ready);
   assign hit_in  = last_tok.found;
   assign key_in  = last_tok.found ? KEY_FIELD_W'(last_tok.best_key) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && take) begin
         hit_ff <= hit_in;
         key_ff <= key_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = hit_ff;
   assign rsp_chan.result_key = key_ff;

endmodule

### hw/rtl/priority_flow_rule_classifier.sv
// Priority five-tuple flow classifier. Each of the RULE_SLOTS rule slots lives in
// its own cell of a chain; every item (rule write or flow lookup) walks the chain
// one cell at a time, so items enter back to back, one per cycle while the chain
// is not stalled; a lookup answers from the response register after passing every
// cell register. Writes and lookups keep their order: a lookup sees exactly the
// writes that were transferred before it. A write returns nothing. The key of
// the highest-priority matching active rule is returned, the lowest slot on a tie.
// The chain stalls only when a lookup reaches its end while an earlier response
// is still waiting. Rules are inactive after reset; no clearing pass is needed.
`include "assert_macros.svh"

module priority_flow_rule_classifier import pfrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pfrc_req_if.sink   req_chan,
   pfrc_rsp_if.source rsp_chan
);

   logic      [RULE_SLOTS:0] link_valid;
   token_type                link_tok [RULE_SLOTS+1];
   logic                     advance;

   assign req_chan.ready = advance;
   assign link_valid[0]  = req_chan.valid;

   always_comb begin
      link_tok[0].func            = func_type'(req_chan.func);
      link_tok[0].slot            = req_chan.slot;
      link_tok[0].rule_enable     = req_chan.rule_enable;
      link_tok[0].proto_code      = req_chan.proto_code;
      link_tok[0].source_addr     = req_chan.source_addr;
      link_tok[0].source_len      = req_chan.source_len;
      link_tok[0].dest_addr       = req_chan.dest_addr;
      link_tok[0].dest_len        = req_chan.dest_len;
      link_tok[0].source_port_num = req_chan.source_port_num;
      link_tok[0].dest_port_num   = req_chan.dest_port_num;
      link_tok[0].rule_prio       = req_chan.rule_prio;
      link_tok[0].key_value       = req_chan.key_value;
      link_tok[0].found           = 1'b0;
      link_tok[0].best_prio       = '0;
      link_tok[0].best_key        = '0;
   end

   for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
      pfrc_rule_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (CELL_IDX_W'(i)),
         .up_valid   (link_valid[i]),
         .up_tok     (link_tok[i]),
         .down_valid (link_valid[i+1]),
         .down_tok   (link_tok[i+1])
      );
   end

   pfrc_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .last_valid (link_valid[RULE_SLOTS]),
      .last_tok   (link_tok[RULE_SLOTS]),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_chan.valid && (link_valid[RULE_SLOTS:1] == '0)), "chain or response not empty after reset")
   `ASSERT_RST(a_stall_holds, clock, reset, !advance |=> $stable(link_valid[RULE_SLOTS:1]), "chain moved during stall")
   `ASSERT_RST(a_lookup_responds, clock, reset, (advance && link_valid[RULE_SLOTS] && (link_tok[RULE_SLOTS].func == FUNC_LOOKUP)) |=> rsp_chan.valid, "lookup left chain without response")
   `ASSERT_RST(a_miss_zero_key, clock, reset, (rsp_chan.valid && !rsp_chan.hit) |-> (rsp_chan.result_key == '0), "miss with nonzero key")

endmodule
